// ===== rtl/core/vpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vpd_pkg;

    // Byte flags and payload masks
    localparam logic [7:0] CONT_BIT  = 8'h80;
    localparam logic [7:0] LOW7_MASK = 8'h7f;
    localparam logic [7:0] LOW4_MASK = 8'h0f;

    // Width of the per-varint byte counter
    localparam int COUNT_W = 4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2
    } t_status;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        t_status              status;
        logic [31:0]          decoded_value;
        logic [COUNT_W-1:0]   prefix_length;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/core/varint_prefix_decoder_u32.sv =====
// Each byte passes through the input register; its result beat goes to the output register.
// Throughput: 1 byte per cycle unless stalled; accumulator update is a mask, shift and OR.
// A byte that causes no result never waits on the output side.
// Reset (synchronous, active low) clears both valid flags, the accumulator and the
// byte counter; the block is ready for a new varint on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module varint_prefix_decoder_u32 #(
    parameter int MAX_PREFIX_BYTES = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  vpd_pkg::t_in_beat   i_in_beat,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output vpd_pkg::t_out_beat  o_out_beat,
    input  wire                 i_out_stall
);
    import vpd_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_POS = COUNT_W'(MAX_PREFIX_BYTES);

    // Input register
    logic                 r_in_valid;
    t_in_beat             r_in_beat;

    // Varint state
    logic [31:0]          r_acc;
    logic [COUNT_W-1:0]   r_count;
    logic [31:0]          n_acc;
    logic [COUNT_W-1:0]   n_count;

    // Output register
    logic                 r_out_valid;
    t_out_beat            r_out_beat;
    t_out_beat            n_out_beat;

    logic [COUNT_W-1:0]   pos;
    logic [31:0]          payload;
    logic [31:0]          acc_sum;
    logic                 has_result;
    logic                 out_free;
    logic                 s1_fire;
    logic                 in_take;

    // Place the payload bits of this byte by its position in the varint
    always_comb begin
        case (r_count)
            4'd0:    payload = {24'd0, r_in_beat.data_byte & LOW7_MASK};
            4'd1:    payload = {18'd0, r_in_beat.data_byte[6:0], 7'd0};
            4'd2:    payload = {11'd0, r_in_beat.data_byte[6:0], 14'd0};
            4'd3:    payload = {4'd0, r_in_beat.data_byte[6:0], 21'd0};
            4'd4:    payload = {(r_in_beat.data_byte[3:0] & LOW4_MASK[3:0]), 28'd0};
            default: payload = 32'd0;
        endcase
    end

    assign pos     = r_count + COUNT_W'(1);
    assign acc_sum = r_acc | payload;

    // Decide the result of the byte in the input register
    always_comb begin
        has_result               = 1'b1;
        n_out_beat.status        = ST_OK;
        n_out_beat.decoded_value = 32'd0;
        n_out_beat.prefix_length = '0;
        n_acc                    = 32'd0;
        n_count                  = '0;
        if ((r_in_beat.data_byte & CONT_BIT) == 8'd0) begin
            n_out_beat.decoded_value = acc_sum;
            n_out_beat.prefix_length = pos;
        end else if (pos >= MAX_POS) begin
            n_out_beat.status = ST_LONG;
        end else if (r_in_beat.buffer_end) begin
            n_out_beat.status = ST_SHORT;
        end else begin
            has_result = 1'b0;
            n_acc      = acc_sum;
            n_count    = pos;
        end
    end

    // Handshake: advance the input stage when it has no result or its result has room
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= 32'd0;
            r_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end
            if (s1_fire && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_acc   <= n_acc;
                r_count <= n_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
        if (s1_fire && has_result) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_OK) |->
        (o_out_beat.decoded_value == 32'd0 && o_out_beat.prefix_length == '0))
        else $error("error beat carries nonzero value or length");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_OK) |->
        (o_out_beat.prefix_length != '0 && o_out_beat.prefix_length <= MAX_POS))
        else $error("decoded beat length out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < MAX_POS)
        else $error("byte counter reached the prefix limit");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_fire) |=> (r_in_valid && $stable(r_in_beat)))
        else $error("stalled input stage lost its byte");
`endif

endmodule

`default_nettype wire
